FILE: rtl/lsra_pkg.sv
// shared types and constants of the lidar sector range averager
package lsra_pkg;

	localparam int SECTORS   = 12;
	localparam int SECTOR_W  = $clog2(SECTORS);
	localparam int RANGE_W   = 16;
	localparam int SUM_W     = 27;
	localparam int CNT_W     = 12;
	localparam int CENTRE_W  = 11;
	localparam int BAND_W    = 10;
	localparam int PACKED_W  = 44;
	localparam int CFG_IDX_W = 3;

	localparam logic [RANGE_W-1:0] MIN_VALID_MM = 16'd10;
	localparam logic [RANGE_W-1:0] EMPTY_MM     = 16'd9900;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_HALF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARDINAL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OBLIQUE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN      = 3'd4;

	typedef struct packed {
		logic sample_ok;
		logic close;
		logic shift;
	} lsra_ctl_t;

endpackage

FILE: rtl/lidar_sector_range_averager.sv
// top level: ray counter, sector cell chain, shared divider and result sequencer
// scan end: from the last_of_scan transfer to out_valid, each sector is loaded in turn;
//   an empty sector passes straight on, a sector with samples goes through the 27-step divider
// throughput: one range sample per cycle; a last_of_scan sample waits while the
//   previous scan's means are still being divided or not yet transferred out
// reset: config registers take their defaults, sums, counts and ray index clear
module lidar_sector_range_averager import lsra_pkg::*; #(
	parameter int MAX_RAYS = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PACKED_W-1:0]  cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [RANGE_W-1:0]   range_mm,
	input  logic                 range_finite,
	input  logic                 last_of_scan,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RANGE_W-1:0]   front_mean,
	output logic [RANGE_W-1:0]   back_mean,
	output logic [RANGE_W-1:0]   left_mean,
	output logic [RANGE_W-1:0]   right_mean,
	output logic [RANGE_W-1:0]   left_front_span_mean,
	output logic [RANGE_W-1:0]   left_back_span_mean,
	output logic [RANGE_W-1:0]   right_front_span_mean,
	output logic [RANGE_W-1:0]   right_back_span_mean,
	output logic [RANGE_W-1:0]   oblique_a_mean,
	output logic [RANGE_W-1:0]   oblique_b_mean,
	output logic [RANGE_W-1:0]   oblique_c_mean,
	output logic [RANGE_W-1:0]   oblique_d_mean
);

	localparam int IDX_W = $clog2(MAX_RAYS);

	typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_OUT} state_t;

	state_t state_q;

	logic [RANGE_W-1:0]  range_max_q;
	logic [BAND_W-1:0]   band_half_q;
	logic [PACKED_W-1:0] cardinal_q, oblique_q, span_q;
	logic [IDX_W-1:0]    ray_q;
	logic [SECTOR_W-1:0] sec_q;
	logic                out_valid_q;
	logic [RANGE_W-1:0]  res_q [SECTORS];

	logic                in_xfer, sample_ok, div_start, div_done, push;
	logic [RANGE_W-1:0]  quotient, push_val;
	lsra_ctl_t           ctl;

	logic [CENTRE_W-1:0] end_a [SECTORS];
	logic [CENTRE_W-1:0] end_b [SECTORS];
	logic                is_win [SECTORS];
	logic [SUM_W-1:0]    hold_sum [SECTORS+1];
	logic [CNT_W-1:0]    hold_cnt [SECTORS+1];

	// only a scan end has to wait for the snapshot chain to be free
	assign in_ready  = (state_q == S_IDLE) || !last_of_scan;
	assign in_xfer   = in_valid && in_ready;
	assign sample_ok = range_finite && (range_mm > MIN_VALID_MM) && (range_mm < range_max_q);

	always_comb begin
		ctl.sample_ok = in_xfer && sample_ok;
		ctl.close     = in_xfer && last_of_scan;
		ctl.shift     = (state_q == S_LOAD);
		div_start     = (state_q == S_LOAD) && (hold_cnt[0] != '0);
		push          = ((state_q == S_LOAD) && (hold_cnt[0] == '0))
			|| ((state_q == S_RUN) && div_done);
		push_val      = (state_q == S_LOAD) ? EMPTY_MM : quotient;
	end

	// sector ends: cardinal windows, four spans around left/right, oblique windows
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			end_a[k]       = cardinal_q[k*CENTRE_W +: CENTRE_W];
			end_b[k]       = cardinal_q[k*CENTRE_W +: CENTRE_W];
			is_win[k]      = 1'b1;
			end_a[k+8]     = oblique_q[k*CENTRE_W +: CENTRE_W];
			end_b[k+8]     = oblique_q[k*CENTRE_W +: CENTRE_W];
			is_win[k+8]    = 1'b1;
			end_a[k+4]     = span_q[k*CENTRE_W +: CENTRE_W];
			end_b[k+4]     = cardinal_q[(2 + k/2)*CENTRE_W +: CENTRE_W];
			is_win[k+4]    = 1'b0;
		end
	end

	assign hold_sum[SECTORS] = '0;
	assign hold_cnt[SECTORS] = '0;

	for (genvar k = 0; k < SECTORS; k++) begin : g_cell
		lsra_cell #(.IDX_W(IDX_W)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.idx       (ray_q),
			.end_a     (end_a[k]),
			.end_b     (end_b[k]),
			.is_window (is_win[k]),
			.band_half (band_half_q),
			.range_mm  (range_mm),
			.nb_sum    (hold_sum[k+1]),
			.nb_cnt    (hold_cnt[k+1]),
			.hold_sum  (hold_sum[k]),
			.hold_cnt  (hold_cnt[k])
		);
	end

	lsra_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (hold_sum[0]),
		.divisor  (hold_cnt[0]),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_max_q <= 16'd12000;
			band_half_q <= 10'd5;
			cardinal_q  <= '0;
			oblique_q   <= '0;
			span_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_MAX: range_max_q <= cfg_data[RANGE_W-1:0];
				REG_BAND_HALF: band_half_q <= cfg_data[BAND_W-1:0];
				REG_CARDINAL:  cardinal_q  <= cfg_data;
				REG_OBLIQUE:   oblique_q   <= cfg_data;
				REG_SPAN:      span_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray_q <= '0;
		end else if (in_xfer) begin
			if (last_of_scan || (ray_q == IDX_W'(MAX_RAYS - 1))) begin
				ray_q <= '0;
			end else begin
				ray_q <= ray_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sec_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					sec_q <= '0;
					if (ctl.close) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (div_start) begin
						state_q <= S_RUN;
					end else if (sec_q == SECTOR_W'(SECTORS - 1)) begin
						state_q     <= S_OUT;
						out_valid_q <= 1'b1;
					end else begin
						sec_q <= sec_q + 1'b1;
					end
				end
				S_RUN: begin
					if (div_done) begin
						if (sec_q == SECTOR_W'(SECTORS - 1)) begin
							state_q     <= S_OUT;
							out_valid_q <= 1'b1;
						end else begin
							sec_q   <= sec_q + 1'b1;
							state_q <= S_LOAD;
						end
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	// result chain: after twelve pushes entry k holds sector k
	always_ff @(posedge clk) begin
		if (push) begin
			for (int k = 0; k < SECTORS - 1; k++) begin
				res_q[k] <= res_q[k+1];
			end
			res_q[SECTORS-1] <= push_val;
		end
	end

	assign out_valid             = out_valid_q;
	assign front_mean            = res_q[0];
	assign back_mean             = res_q[1];
	assign left_mean             = res_q[2];
	assign right_mean            = res_q[3];
	assign left_front_span_mean  = res_q[4];
	assign left_back_span_mean   = res_q[5];
	assign right_front_span_mean = res_q[6];
	assign right_back_span_mean  = res_q[7];
	assign oblique_a_mean        = res_q[8];
	assign oblique_b_mean        = res_q[9];
	assign oblique_c_mean        = res_q[10];
	assign oblique_d_mean        = res_q[11];

endmodule

FILE: rtl/lsra_cell.sv
// one sector cell: window or span test, saturating accumulator and snapshot stage
module lsra_cell import lsra_pkg::*; #(
	parameter int IDX_W = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lsra_ctl_t           ctl,
	input  logic [IDX_W-1:0]    idx,
	input  logic [CENTRE_W-1:0] end_a,
	input  logic [CENTRE_W-1:0] end_b,
	input  logic                is_window,
	input  logic [BAND_W-1:0]   band_half,
	input  logic [RANGE_W-1:0]  range_mm,
	input  logic [SUM_W-1:0]    nb_sum,
	input  logic [CNT_W-1:0]    nb_cnt,
	output logic [SUM_W-1:0]    hold_sum,
	output logic [CNT_W-1:0]    hold_cnt
);

	localparam int CW = ((IDX_W > CENTRE_W) ? IDX_W : CENTRE_W) + 2;

	logic [CW-1:0]    idx_x, a_x, b_x, bh_x, lo_x, hi_x;
	logic             win_hit, span_hit, take;
	logic [SUM_W:0]   sum_add;
	logic [SUM_W-1:0] sum_sat, sum_cur, acc_sum_q, hold_sum_q;
	logic [CNT_W-1:0] cnt_inc, cnt_cur, acc_cnt_q, hold_cnt_q;

	always_comb begin
		idx_x    = CW'(idx);
		a_x      = CW'(end_a);
		b_x      = CW'(end_b);
		bh_x     = CW'(band_half);
		lo_x     = (a_x < b_x) ? a_x : b_x;
		hi_x     = (a_x < b_x) ? b_x : a_x;
		win_hit  = (idx_x + bh_x >= a_x) && (idx_x <= a_x + bh_x);
		span_hit = (idx_x >= lo_x) && (idx_x <= hi_x);
		take     = ctl.sample_ok && (is_window ? win_hit : span_hit);
		// a single range below 2^16 can only overflow through the carry
		sum_add  = {1'b0, acc_sum_q} + (SUM_W+1)'(range_mm);
		sum_sat  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
		cnt_inc  = (acc_cnt_q == '1) ? acc_cnt_q : acc_cnt_q + 1'b1;
		sum_cur  = take ? sum_sat : acc_sum_q;
		cnt_cur  = take ? cnt_inc : acc_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_sum_q <= '0;
			acc_cnt_q <= '0;
		end else if (ctl.close) begin
			acc_sum_q <= '0;
			acc_cnt_q <= '0;
		end else begin
			acc_sum_q <= sum_cur;
			acc_cnt_q <= cnt_cur;
		end
	end

	// snapshot of the closed scan, shifted toward the divider
	always_ff @(posedge clk) begin
		if (ctl.close) begin
			hold_sum_q <= sum_cur;
			hold_cnt_q <= cnt_cur;
		end else if (ctl.shift) begin
			hold_sum_q <= nb_sum;
			hold_cnt_q <= nb_cnt;
		end
	end

	assign hold_sum = hold_sum_q;
	assign hold_cnt = hold_cnt_q;

endmodule

FILE: rtl/lsra_div.sv
// restoring divider, one quotient bit per cycle
module lsra_div import lsra_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   dividend,
	input  logic [CNT_W-1:0]   divisor,
	output logic               done,
	output logic [RANGE_W-1:0] quotient
);

	localparam int STEP_W = $clog2(SUM_W);

	logic [SUM_W-1:0]  q_q;
	logic [CNT_W-1:0]  rem_q, div_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q, done_q;
	logic [CNT_W:0]    rem_sh, diff;
	logic              fits;

	always_comb begin
		rem_sh = {rem_q, q_q[SUM_W-1]};
		diff   = rem_sh - {1'b0, div_q};
		fits   = rem_sh >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			q_q   <= {q_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = q_q[RANGE_W-1:0];

endmodule

FILE: bench/tb.sv
// testbench of the lidar sector range averager: per-scan sector means against a bit-true predictor
module tb;
	import lsra_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT     = 4000;
	localparam int SETTLE_CYCLES  = 360;
	localparam int LONG_SCAN_RAYS = 2100;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_RAYS     = 60;
	localparam int MAX_REPORTS    = 40;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
	localparam logic [SUM_W-1:0]     SUM_SAT    = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0]     CNT_SAT    = {CNT_W{1'b1}};

	typedef logic [SECTORS-1:0][RANGE_W-1:0] mean_set_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_LONG_STALL
	} ready_mode_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [PACKED_W-1:0]  cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_ready;
	logic [RANGE_W-1:0]   range_mm     = '0;
	logic                 range_finite = 1'b0;
	logic                 last_of_scan = 1'b0;
	logic                 out_valid;
	logic                 out_ready    = 1'b0;
	logic [RANGE_W-1:0]   front_mean, back_mean, left_mean, right_mean;
	logic [RANGE_W-1:0]   left_front_span_mean, left_back_span_mean;
	logic [RANGE_W-1:0]   right_front_span_mean, right_back_span_mean;
	logic [RANGE_W-1:0]   oblique_a_mean, oblique_b_mean, oblique_c_mean, oblique_d_mean;

	lidar_sector_range_averager uut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.range_mm             (range_mm),
		.range_finite         (range_finite),
		.last_of_scan         (last_of_scan),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.front_mean           (front_mean),
		.back_mean            (back_mean),
		.left_mean            (left_mean),
		.right_mean           (right_mean),
		.left_front_span_mean (left_front_span_mean),
		.left_back_span_mean  (left_back_span_mean),
		.right_front_span_mean(right_front_span_mean),
		.right_back_span_mean (right_back_span_mean),
		.oblique_a_mean       (oblique_a_mean),
		.oblique_b_mean       (oblique_b_mean),
		.oblique_c_mean       (oblique_c_mean),
		.oblique_d_mean       (oblique_d_mean)
	);

	string sector_label [SECTORS] = '{
		"front_mean", "back_mean", "left_mean", "right_mean",
		"left_front_span_mean", "left_back_span_mean",
		"right_front_span_mean", "right_back_span_mean",
		"oblique_a_mean", "oblique_b_mean", "oblique_c_mean", "oblique_d_mean"
	};

	// predictor copy of the registers and the accumulators
	logic [RANGE_W-1:0]  cfg_range_max;
	logic [BAND_W-1:0]   cfg_band_half;
	logic [PACKED_W-1:0] cfg_cardinal, cfg_oblique, cfg_span;
	logic [CENTRE_W-1:0] next_ray;
	logic [SUM_W-1:0]    sector_sum [SECTORS];
	logic [CNT_W-1:0]    sector_cnt [SECTORS];

	mean_set_t   expected_means_q [$];
	int          mismatches    = 0;
	int          rays_sent     = 0;
	int          scans_checked = 0;
	int          burst_left    = 0;
	int          idle_cycles   = 0;
	int          ready_tick    = 0;
	ready_mode_t ready_mode    = READY_ALWAYS;

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic logic [CENTRE_W-1:0] slot11(input logic [PACKED_W-1:0] word, input int k);
		return word[k*CENTRE_W +: CENTRE_W];
	endfunction

	function automatic logic [PACKED_W-1:0] pack4(input logic [CENTRE_W-1:0] a, b, c, d);
		return {d, c, b, a};
	endfunction

	function automatic logic in_window(input logic [CENTRE_W-1:0] ray, centre);
		logic [CENTRE_W-1:0] gap;
		gap = (ray > centre) ? ray - centre : centre - ray;
		return gap <= {1'b0, cfg_band_half};
	endfunction

	function automatic logic in_span(input logic [CENTRE_W-1:0] ray, a, b);
		logic [CENTRE_W-1:0] lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return ray >= lo && ray <= hi;
	endfunction

	function automatic void reset_predictor();
		cfg_range_max = 16'd12000;
		cfg_band_half = 10'd5;
		cfg_cardinal  = '0;
		cfg_oblique   = '0;
		cfg_span      = '0;
		next_ray      = '0;
		for (int k = 0; k < SECTORS; k++) begin
			sector_sum[k] = '0;
			sector_cnt[k] = '0;
		end
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PACKED_W-1:0] data);
		case (idx)
			REG_RANGE_MAX: cfg_range_max = data[RANGE_W-1:0];
			REG_BAND_HALF: cfg_band_half = data[BAND_W-1:0];
			REG_CARDINAL:  cfg_cardinal  = data;
			REG_OBLIQUE:   cfg_oblique   = data;
			REG_SPAN:      cfg_span      = data;
			default: ;
		endcase
	endfunction

	// accumulate one accepted ray; the last ray of a scan yields the twelve means
	function automatic void predict_ray(input logic [RANGE_W-1:0] mm, input logic finite, last);
		logic [SECTORS-1:0]  hit;
		logic [SUM_W:0]      acc;
		logic [SUM_W-1:0]    quot;
		logic [CENTRE_W-1:0] cl, cr;
		mean_set_t           means;
		cl = slot11(cfg_cardinal, 2);
		cr = slot11(cfg_cardinal, 3);
		for (int k = 0; k < 4; k++) begin
			hit[k]     = in_window(next_ray, slot11(cfg_cardinal, k));
			hit[8 + k] = in_window(next_ray, slot11(cfg_oblique, k));
		end
		hit[4] = in_span(next_ray, slot11(cfg_span, 0), cl);
		hit[5] = in_span(next_ray, cl, slot11(cfg_span, 1));
		hit[6] = in_span(next_ray, slot11(cfg_span, 2), cr);
		hit[7] = in_span(next_ray, cr, slot11(cfg_span, 3));
		if (finite && mm > MIN_VALID_MM && mm < cfg_range_max) begin
			for (int k = 0; k < SECTORS; k++) begin
				if (hit[k]) begin
					acc = sector_sum[k] + mm;
					sector_sum[k] = (acc > SUM_SAT) ? SUM_SAT : acc[SUM_W-1:0];
					if (sector_cnt[k] != CNT_SAT)
						sector_cnt[k] = sector_cnt[k] + 1'b1;
				end
			end
		end
		if (last) begin
			for (int k = 0; k < SECTORS; k++) begin
				if (sector_cnt[k] == '0) begin
					means[k] = EMPTY_MM;
				end else begin
					quot = sector_sum[k] / sector_cnt[k];
					means[k] = quot[RANGE_W-1:0];
				end
				sector_sum[k] = '0;
				sector_cnt[k] = '0;
			end
			next_ray = '0;
			expected_means_q = {expected_means_q, means};
		end else begin
			next_ray = next_ray + 1'b1;
		end
	endfunction

	// one sample, sent in bursts with random gaps between them
	task automatic send_ray(input logic [RANGE_W-1:0] mm, input logic finite, last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		range_mm     <= mm;
		range_finite <= finite;
		last_of_scan <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		rays_sent++;
		predict_ray(mm, finite, last);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PACKED_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, data);
		@(posedge clk);
	endtask

	// sender holds off until every pending scan result has been transferred
	task automatic hold_for_results();
		if (expected_means_q.size() != 0) begin
			in_valid <= 1'b0;
			while (expected_means_q.size() != 0)
				@(posedge clk);
		end
	endtask

	// quiet point for register writes: all results out, pipeline settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_means_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CENTRE_W-1:0] random_index(input int scale);
		if ($urandom_range(0, 7) == 0)
			return CENTRE_W'($urandom_range(0, 2047));
		return CENTRE_W'($urandom_range(0, scale + 4));
	endfunction

	function automatic logic [RANGE_W-1:0] random_mm();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return RANGE_W'($urandom_range(0, 12));
		if (sel == 1)
			return cfg_range_max + RANGE_W'($urandom_range(0, 2)) - 1'b1;
		if (sel == 2 || cfg_range_max <= 16'd12)
			return RANGE_W'($urandom_range(0, 65535));
		return RANGE_W'($urandom_range(11, cfg_range_max - 1'b1));
	endfunction

	task automatic test_reset_defaults();
		// windows 0..5 around ray 0, spans only ray 0
		send_ray(16'd11, 1'b1, 1'b0);
		send_ray(16'd10, 1'b1, 1'b0);
		send_ray(16'd11999, 1'b1, 1'b0);
		send_ray(16'd12000, 1'b1, 1'b0);
		send_ray(16'd0, 1'b1, 1'b0);
		send_ray(16'd65535, 1'b1, 1'b0);
		send_ray(16'd500, 1'b0, 1'b0);
		send_ray(16'd5000, 1'b1, 1'b1);
		// single-ray scan with nothing valid
		send_ray(16'd0, 1'b1, 1'b1);
	endtask

	task automatic test_register_extremes();
		wait_idle();
		write_reg(REG_RANGE_MAX, 44'hFFF_FFFF_FFFF);
		write_reg(REG_BAND_HALF, 44'hFFF_FFFF_FC00);
		write_reg(REG_CARDINAL, pack4(11'd0, 11'd1, 11'd2, 11'd3));
		write_reg(REG_OBLIQUE, pack4(11'd4, 11'd5, 11'd6, 11'd7));
		// spans given in reversed order, one collapsed, one past the scan
		write_reg(REG_SPAN, pack4(11'd6, 11'd0, 11'd3, 11'd2047));
		write_reg(REG_UNUSED, PACKED_W'({$urandom, $urandom}));
		send_ray(16'd65534, 1'b1, 1'b0);
		send_ray(16'd11, 1'b1, 1'b0);
		send_ray(16'd65535, 1'b1, 1'b0);
		send_ray(16'd30000, 1'b1, 1'b0);
		send_ray(16'd40000, 1'b0, 1'b0);
		send_ray(16'd12345, 1'b1, 1'b0);
		send_ray(16'd777, 1'b1, 1'b0);
		send_ray(16'd65534, 1'b1, 1'b1);
		wait_idle();
		write_reg(REG_RANGE_MAX, 44'd11);
		write_reg(REG_BAND_HALF, 44'd1023);
		send_ray(16'd11, 1'b1, 1'b0);
		send_ray(16'd10, 1'b1, 1'b0);
		send_ray(16'd12, 1'b1, 1'b1);
	endtask

	// ray index wraps once, sums of the widest sectors saturate
	task automatic test_long_scan();
		wait_idle();
		write_reg(REG_RANGE_MAX, 44'd65535);
		write_reg(REG_BAND_HALF, 44'd1023);
		write_reg(REG_CARDINAL, pack4(11'd0, 11'd1024, 11'd2047, 11'd1000));
		write_reg(REG_OBLIQUE, pack4(11'd300, 11'd1500, 11'd2047, 11'd2));
		write_reg(REG_SPAN, pack4(11'd0, 11'd1800, 11'd2047, 11'd0));
		for (int i = 0; i < LONG_SCAN_RAYS; i++)
			send_ray(16'd65534, (i % 50) != 7, i == LONG_SCAN_RAYS - 1);
	endtask

	task automatic test_random_scans();
		int scale, sent, len;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			scale = (phase == 0) ? 4 : $urandom_range(6, 80);
			wait_idle();
			case (phase)
				1: write_reg(REG_RANGE_MAX, 44'd65535);
				2: write_reg(REG_RANGE_MAX, PACKED_W'({$urandom, 16'd12}));
				default: write_reg(REG_RANGE_MAX,
					PACKED_W'({$urandom, 16'($urandom_range(200, 65535))}));
			endcase
			case (phase)
				3: write_reg(REG_BAND_HALF, 44'd0);
				4: write_reg(REG_BAND_HALF, 44'd1023);
				default: write_reg(REG_BAND_HALF, 44'($urandom_range(0, scale / 2 + 1)));
			endcase
			if (phase == 5) begin
				write_reg(REG_CARDINAL, PACKED_W'({$urandom, $urandom}));
				write_reg(REG_OBLIQUE, PACKED_W'({$urandom, $urandom}));
				write_reg(REG_SPAN, PACKED_W'({$urandom, $urandom}));
			end else begin
				write_reg(REG_CARDINAL, pack4(random_index(scale), random_index(scale),
					random_index(scale), random_index(scale)));
				write_reg(REG_OBLIQUE, pack4(random_index(scale), random_index(scale),
					random_index(scale), random_index(scale)));
				write_reg(REG_SPAN, pack4(random_index(scale), random_index(scale),
					random_index(scale), random_index(scale)));
			end
			sent = 0;
			while (sent < PHASE_RAYS) begin
				len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 2 * scale);
				for (int i = 0; i < len; i++)
					send_ray(random_mm(), $urandom_range(0, 11) != 0, i == len - 1);
				sent += len;
				if ($urandom_range(0, 7) == 0)
					hold_for_results();
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		mean_set_t got, want;
		if (out_valid && out_ready) begin
			got = {oblique_d_mean, oblique_c_mean, oblique_b_mean, oblique_a_mean,
				right_back_span_mean, right_front_span_mean,
				left_back_span_mean, left_front_span_mean,
				right_mean, left_mean, back_mean, front_mean};
			if (expected_means_q.size() == 0) begin
				report_mismatch("scan result with no scan pending");
			end else begin
				want = expected_means_q.pop_front();
				scans_checked++;
				for (int k = 0; k < SECTORS; k++) begin
					if (got[k] !== want[k])
						report_mismatch($sformatf("scan %0d %s: got %0d, expected %0d",
							scans_checked, sector_label[k], got[k], want[k]));
				end
			end
		end
	end

	// receiver stall pattern, picked at random from the four ready modes
	always @(posedge clk) begin
		ready_tick <= ready_tick + 1;
		if (ready_tick % 256 == 0)
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
		case (ready_mode)
			READY_ALWAYS:     out_ready <= 1'b1;
			READY_COIN:       out_ready <= 1'($urandom_range(0, 1));
			READY_SPARSE:     out_ready <= (ready_tick % 5 == 0);
			READY_LONG_STALL: out_ready <= (ready_tick % 48 < 12);
			default:          out_ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		reset_predictor();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_long_scan();
		test_random_scans();
		wait_idle();
		$display("covered %0d range samples in %0d checked scans, register extremes and defaults,",
			rays_sent, scans_checked);
		$display("a %0d-ray wrapping scan with saturated sums, %0d random phases",
			LONG_SCAN_RAYS, RANDOM_PHASES);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
